>>> design/iord_pkg.sv
// Shared types and constants of the in-flight range overlap detector.
// No dependencies; imported by the top level.
`default_nettype none

package iord_pkg;

  // Input field widths
  localparam int unsigned START_W = 48;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TAG_W   = 5;

  // Result field widths
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CONFLICT_W = 6;

  // Stream word widths (padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  // Conflict counter saturates here
  localparam logic [CONFLICT_W-1:0] CONFLICT_MAX = '1;

  // Operation carried in in_tuser
  typedef enum logic {
    OP_ISSUE    = 1'b0,
    OP_COMPLETE = 1'b1
  } iord_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_TAG = 2'd2
  } iord_status_t;

endpackage

`default_nettype wire

>>> design/iord_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the range table of the overlap detector.
`default_nettype none

module iord_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/iord_cmp.sv
// Shared conflict compare unit: one table entry against the pending request.
// No dependencies; used once per scanned entry by the top level.
`default_nettype none

module iord_cmp #(
  parameter int unsigned SECTOR_BITS = 48
) (
  input  wire logic [SECTOR_BITS-1:0] req_begin,
  input  wire logic [SECTOR_BITS:0]   req_end,
  input  wire logic                   req_write,
  input  wire logic [SECTOR_BITS-1:0] ent_begin,
  input  wire logic [SECTOR_BITS:0]   ent_end,
  input  wire logic                   ent_write,
  output logic                        hit
);

  logic apart;

  // half-open ranges are disjoint when one ends at or before the other starts
  always_comb begin
    apart = (ent_end <= {1'b0, req_begin}) || (req_end <= {1'b0, ent_begin});
    hit   = (ent_write || req_write) && !apart;
  end

endmodule

`default_nettype wire

>>> design/inflight_range_overlap_detector.sv
// Top level of the in-flight range overlap detector: sequencer, valid bits, result register.
// Depends on iord_pkg, iord_ram (range table) and iord_cmp (conflict compare unit).
`default_nettype none

// Keeps a table of TABLE_DEPTH outstanding storage requests, each a half-open
// sector range plus a write flag. An issue word (in_tuser = 0) walks the whole
// table through one shared compare unit, one entry per cycle, counting the valid
// entries that overlap the new range (two reads never conflict) and noting the
// lowest free slot on the way; the request is then written to that slot and the
// slot comes back as its tag. A full table gives status 1 and stores nothing.
// A complete word (in_tuser = 1) frees done_tag, or reports status 2 when that
// tag is not in use. The issue scan is paced by the single table read port and
// the single compare unit. A result is written to the output register once
// that register is free. One word is in work at a time; in_tready is high
// only when the sequencer is idle, and a finished result waits in the output
// register while the next word is accepted.
// The table starts empty after reset, no clearing pass is needed.
module inflight_range_overlap_detector
  import iord_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata, low bit up: start_sector[47:0], sector_count[63:48], wr_flag[64],
  // done_tag[69:65], zero pad[71:70]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op (0 issue, 1 complete)
  input  wire logic                  in_tuser,
  // out_tdata, low bit up: status[1:0], slot_tag[6:2], race_found[7],
  // conflict_count[13:8], zero pad[15:14]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ENT_W  = 2 * SECTOR_BITS + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  // ---- input word fields
  logic [START_W-1:0] in_start;
  logic [COUNT_W-1:0] in_count;
  logic               in_write;
  logic [TAG_W-1:0]   in_tag;
  logic [63:0]        start_ext;

  assign in_start  = in_tdata[START_W-1:0];
  assign in_count  = in_tdata[START_W+COUNT_W-1:START_W];
  assign in_write  = in_tdata[START_W+COUNT_W];
  assign in_tag    = in_tdata[START_W+COUNT_W+TAG_W:START_W+COUNT_W+1];
  assign start_ext = 64'(in_start);

  // ---- registers
  state_t                 state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  iord_op_t               op_r, op_nxt;
  logic [SECTOR_BITS-1:0] req_begin_r, req_begin_nxt;
  logic [SECTOR_BITS:0]   req_end_r, req_end_nxt;
  logic                   req_write_r, req_write_nxt;
  logic [TAG_W-1:0]       tag_r, tag_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;       // next entry to read
  logic                   chk_vld_r, chk_vld_nxt; // read data in flight is due
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [CONFLICT_W-1:0]  count_r, count_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_slot_r, free_slot_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  // ---- table RAM and compare unit
  logic             ram_wr_en, ram_rd_en;
  logic [ENT_W-1:0] ram_wr_data, ram_rd_data;
  logic             hit;

  iord_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (free_slot_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  // entry word: {write, end, begin}
  iord_cmp #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_cmp (
    .req_begin (req_begin_r),
    .req_end   (req_end_r),
    .req_write (req_write_r),
    .ent_begin (ram_rd_data[SECTOR_BITS-1:0]),
    .ent_end   (ram_rd_data[2*SECTOR_BITS:SECTOR_BITS]),
    .ent_write (ram_rd_data[ENT_W-1]),
    .hit       (hit)
  );

  assign ram_wr_data = {req_write_r, req_end_r, req_begin_r};
  assign ram_rd_en   = (state_r == S_SCAN);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---- completion tag lookup
  logic             tag_in_range;
  logic [IDX_W-1:0] tag_idx;
  logic             tag_live;
  logic             out_free;

  assign tag_in_range = (32'(tag_r) < 32'(TABLE_DEPTH));
  assign tag_idx      = IDX_W'(tag_r);
  assign tag_live     = tag_in_range && valid_r[tag_idx];
  assign out_free     = !out_tvalid_r || out_tready;

  // ---- sequencer
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    op_nxt         = op_r;
    req_begin_nxt  = req_begin_r;
    req_end_nxt    = req_end_r;
    req_write_nxt  = req_write_r;
    tag_nxt        = tag_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    count_nxt      = count_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_wr_en      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // compare stage: entry read last cycle is checked now
    if (chk_vld_r) begin
      if (valid_r[chk_idx_r]) begin
        if (hit && (count_r != CONFLICT_MAX)) begin
          count_nxt = count_r + 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = chk_idx_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = iord_op_t'(in_tuser);
          req_begin_nxt  = start_ext[SECTOR_BITS-1:0];
          req_end_nxt    = {1'b0, start_ext[SECTOR_BITS-1:0]} + (SECTOR_BITS+1)'(in_count);
          req_write_nxt  = in_write;
          tag_nxt        = in_tag;
          idx_nxt        = '0;
          count_nxt      = '0;
          free_found_nxt = 1'b0;
          free_slot_nxt  = '0;
          state_nxt      = (iord_op_t'(in_tuser) == OP_ISSUE) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        // last entry is compared this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (op_r == OP_COMPLETE) begin
            out_tdata_nxt = '0;
            if (tag_live) begin
              valid_nxt[tag_idx] = 1'b0;
              out_tdata_nxt[STATUS_W-1:0] = ST_OK;
            end else begin
              out_tdata_nxt[STATUS_W-1:0] = ST_BAD_TAG;
            end
          end else if (free_found_r) begin
            ram_wr_en                = 1'b1;
            valid_nxt[free_slot_r]   = 1'b1;
            out_tdata_nxt            = '0;
            out_tdata_nxt[STATUS_W-1:0] = ST_OK;
            out_tdata_nxt[STATUS_W+TAG_W-1:STATUS_W] = TAG_W'(free_slot_r);
            out_tdata_nxt[STATUS_W+TAG_W] = (count_r != '0);
            out_tdata_nxt[STATUS_W+TAG_W+CONFLICT_W:STATUS_W+TAG_W+1] = count_r;
          end else begin
            out_tdata_nxt = '0;
            out_tdata_nxt[STATUS_W-1:0] = ST_FULL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      chk_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r         <= op_nxt;
    req_begin_r  <= req_begin_nxt;
    req_end_r    <= req_end_nxt;
    req_write_r  <= req_write_nxt;
    tag_r        <= tag_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    count_r      <= count_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

endmodule

`default_nettype wire
